FILE: src/bcdu_pkg.sv
// Package: shared types, constants and decode helpers for the BCD calendar converter.
`default_nettype none

package bcdu_pkg;

    localparam int unsigned DEF_QUEUE_DEPTH = 2;

    // Day counts from 1970-01-01 to the March 1 that starts the shifted year.
    localparam logic [16:0] DAYS_TO_MAR_2000 = 17'd11017;
    localparam logic [16:0] DAYS_TO_MAR_1999 = 17'd10651;

    localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
    localparam logic [16:0] SECS_PER_MIN  = 17'd60;
    localparam logic [31:0] SECS_PER_DAY  = 32'd86400;

    typedef struct packed {
        logic [31:0] time_word;
        logic [31:0] date_word;
    } item_t;

    typedef struct packed {
        logic [31:0] epoch_secs;
        logic        status;
    } result_t;

    // Decoded and classified item passed from front to back.
    typedef struct packed {
        logic       bad;
        logic [7:0] year;
        logic       early;
        logic [3:0] mp;
        logic [5:0] day;
        logic [5:0] hour;
        logic [6:0] minute;
        logic [6:0] second;
    } fields_t;

    function automatic logic [7:0] bcd_decode(input logic [7:0] v);
        return ({4'd0, v[7:4]} * 8'd10) + {4'd0, v[3:0]};
    endfunction

    // Days from March 1 to the first day of the shifted month.
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] d;
        case (mp)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd61;
            4'd3:    d = 9'd92;
            4'd4:    d = 9'd122;
            4'd5:    d = 9'd153;
            4'd6:    d = 9'd184;
            4'd7:    d = 9'd214;
            4'd8:    d = 9'd245;
            4'd9:    d = 9'd275;
            4'd10:   d = 9'd306;
            4'd11:   d = 9'd337;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

FILE: src/bcd_calendar_to_unix_seconds_core.sv
// Top level: BCD RTC time/date words to Unix seconds.
//
// Input channel item_valid/item_stall carries one item_t (time_word, date_word);
// a transfer happens on a rising edge with item_valid high and item_stall low.
// Output channel result_valid/result_stall carries one result_t per item, in order:
// epoch_secs and status (1 = a decoded field out of range, seconds forced to 0).
// An item transfer loads the front register, then a queue slot, the day-count register
// and the seconds register, which raises result_valid.
// Throughput is one item per cycle while result_stall is low; the constant multiplies
// are split between the back stages.
// A stalled result holds; items keep entering until the back stages, the queue
// (QUEUE_DEPTH entries) and the front register fill, then item_stall rises.
// Reset (rst_n low, asynchronous) drops all valid flags and empties the queue;
// the data registers are not reset.
`default_nettype none

module bcd_calendar_to_unix_seconds_core
    import bcdu_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    item_valid,
    output logic         item_stall,
    input  wire item_t   item,
    output logic         result_valid,
    input  wire logic    result_stall,
    output result_t      result
);

    logic    cls_valid;
    logic    cls_stall;
    fields_t cls;
    logic    q_valid;
    logic    q_stall;
    fields_t q_data;

    bcdu_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .cls_valid  (cls_valid),
        .cls_stall  (cls_stall),
        .cls        (cls)
    );

    bcdu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (cls_valid),
        .push_stall (cls_stall),
        .push_data  (cls),
        .pop_valid  (q_valid),
        .pop_stall  (q_stall),
        .pop_data   (q_data)
    );

    bcdu_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .fields_valid (q_valid),
        .fields_stall (q_stall),
        .fields       (q_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire

FILE: src/bcdu_front.sv
// Front stage: BCD field decode, range classification and output register.
`default_nettype none

module bcdu_front
    import bcdu_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    item_valid,
    output logic         item_stall,
    input  wire item_t   item,
    output logic         cls_valid,
    input  wire logic    cls_stall,
    output fields_t      cls
);

    logic    cls_valid_reg;
    logic    cls_valid_next;
    fields_t cls_reg;
    fields_t cls_next;
    logic    ready;
    logic    take;

    logic [6:0] second;
    logic [6:0] minute;
    logic [5:0] hour;
    logic [5:0] day;
    logic [4:0] month;
    logic [7:0] year;

    assign ready      = !cls_valid_reg || !cls_stall;
    assign item_stall = !ready;
    assign take       = item_valid && ready;

    always_comb
    begin
        second = 7'(bcd_decode({1'b0, item.time_word[6:0]}));
        minute = 7'(bcd_decode({1'b0, item.time_word[14:8]}));
        hour   = 6'(bcd_decode({2'b0, item.time_word[21:16]}));
        day    = 6'(bcd_decode({2'b0, item.date_word[5:0]}));
        month  = 5'(bcd_decode({3'b0, item.date_word[12:8]}));
        year   = bcd_decode(item.date_word[23:16]);

        cls_next.bad    = (month == 5'd0) || (month > 5'd12) || (day == 6'd0) ||
                          (day > 6'd31) || (hour > 6'd23) || (minute > 7'd59) ||
                          (second > 7'd59);
        cls_next.year   = year;
        cls_next.early  = (month <= 5'd2);
        cls_next.mp     = (month <= 5'd2) ? 4'(month + 5'd9) : 4'(month - 5'd3);
        cls_next.day    = day;
        cls_next.hour   = hour;
        cls_next.minute = minute;
        cls_next.second = second;
    end

    assign cls_valid_next = take ? 1'b1 : (cls_stall ? cls_valid_reg : 1'b0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cls_valid_reg <= 1'b0;
        end
        else
        begin
            cls_valid_reg <= cls_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cls_reg <= cls_next;
        end
    end

    assign cls_valid = cls_valid_reg;
    assign cls       = cls_reg;

endmodule

`default_nettype wire

FILE: src/bcdu_queue.sv
// Short queue between front and back stages.
`default_nettype none

module bcdu_queue
    import bcdu_pkg::*;
#(
    parameter int unsigned DEPTH = DEF_QUEUE_DEPTH
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push_valid,
    output logic         push_stall,
    input  wire fields_t push_data,
    output logic         pop_valid,
    input  wire logic    pop_stall,
    output fields_t      pop_data
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    fields_t            mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               full;
    logic               push;
    logic               pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign push_stall = full;
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && !full;
    assign pop        = pop_valid && !pop_stall;
    assign pop_data   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_reg + 1'b1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_reg + 1'b1);
        end
        if (push && !pop)
        begin
            count_next = CNT_W'(count_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            count_next = CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == CNT_W'($past(count_reg) + 1'b1)))
        else $error("queue count missed a push");

    a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> (count_reg == CNT_W'($past(count_reg) - 1'b1)))
        else $error("queue count missed a pop");

endmodule

`default_nettype wire

FILE: src/bcdu_back.sv
// Back stages: day count and time of day, then seconds product and result register.
`default_nettype none

module bcdu_back
    import bcdu_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    fields_valid,
    output logic         fields_stall,
    input  wire fields_t fields,
    output logic         result_valid,
    input  wire logic    result_stall,
    output result_t      result
);

    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic [16:0] days_reg;
    logic [16:0] days_next;
    logic [16:0] tod_reg;
    logic [16:0] tod_next;
    logic        bad_reg;

    logic        result_valid_reg;
    logic        result_valid_next;
    result_t     result_reg;
    result_t     result_next;

    logic        ready1;
    logic        ready2;
    logic        take1;
    logic        take2;

    logic [7:0]  yr_adj;
    logic [16:0] yr_days;
    logic [16:0] doy;
    logic [31:0] day_secs;

    assign ready2       = !result_valid_reg || !result_stall;
    assign ready1       = !s1_valid_reg || ready2;
    assign fields_stall = !ready1;
    assign take1        = fields_valid && ready1;
    assign take2        = s1_valid_reg && ready2;

    always_comb
    begin
        yr_adj  = 8'(fields.year - {7'd0, fields.early});
        yr_days = 17'({9'd0, yr_adj} * 17'd365) + 17'(yr_adj[7:2]) -
                  ((yr_adj >= 8'd100) ? 17'd1 : 17'd0);
        doy     = 17'(month_start(fields.mp)) + 17'(fields.day) - 17'd1;
        if (fields.early && (fields.year == 8'd0))
        begin
            days_next = DAYS_TO_MAR_1999 + doy;
        end
        else
        begin
            days_next = DAYS_TO_MAR_2000 + yr_days + doy;
        end
        tod_next = 17'(17'(fields.hour) * SECS_PER_HOUR) +
                   17'(17'(fields.minute) * SECS_PER_MIN) + 17'(fields.second);
    end

    always_comb
    begin
        day_secs = {15'd0, days_reg} * SECS_PER_DAY;
        result_next.status     = bad_reg;
        result_next.epoch_secs = bad_reg ? 32'd0 : (day_secs + {15'd0, tod_reg});
    end

    assign s1_valid_next     = take1 ? 1'b1 : (ready2 ? 1'b0 : s1_valid_reg);
    assign result_valid_next = take2 ? 1'b1 : (result_stall ? result_valid_reg : 1'b0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg     <= s1_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take1)
        begin
            days_reg <= days_next;
            tod_reg  <= tod_next;
            bad_reg  <= fields.bad;
        end
        if (take2)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_reg.status) |-> (result_reg.epoch_secs == 32'd0))
        else $error("flagged result carries nonzero seconds");

    a_s1_moves: assert property (@(posedge clk) disable iff (!rst_n)
        take2 |=> (result_valid_reg && (result_reg.status == $past(bad_reg))))
        else $error("stage one transfer lost");

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_stall) |=> (result_valid_reg && $stable(result_reg)))
        else $error("stalled result changed");

endmodule

`default_nettype wire

FILE: test/bcd_calendar_to_unix_seconds_core_tb.sv
// Testbench for the BCD calendar to Unix seconds core: directed and random traffic.
module bcd_calendar_to_unix_seconds_core_tb;
    import bcdu_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned SETTLE_CYCLES  = 8;
    localparam int unsigned REPORT_CAP     = 100;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    item_valid = 1'b0;
    logic    item_stall;
    item_t   item = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    result_t     pending_stamps[$];
    int unsigned mismatch_count = 0;
    int unsigned stuck_cycles = 0;
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct = 0;

    bcd_calendar_to_unix_seconds_core dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned digit_pair(input logic [7:0] v);
        return int'(v[7:4]) * 10 + int'(v[3:0]);
    endfunction

    // Expected timestamp for one register pair.
    function automatic result_t civil_to_unix(input item_t it);
        int unsigned sec, mn, hr, dd, mo, yr, y, era, yoe, mp, doy, doe, days;
        longint unsigned total;
        result_t r;
        sec = digit_pair({1'b0, it.time_word[6:0]});
        mn  = digit_pair({1'b0, it.time_word[14:8]});
        hr  = digit_pair({2'b0, it.time_word[21:16]});
        dd  = digit_pair({2'b0, it.date_word[5:0]});
        mo  = digit_pair({3'b0, it.date_word[12:8]});
        yr  = 2000 + digit_pair(it.date_word[23:16]);
        r.epoch_secs = '0;
        r.status = 1'b1;
        if (mo == 0 || mo > 12 || dd == 0 || dd > 31 || hr > 23 || mn > 59 || sec > 59)
            return r;
        y    = (mo <= 2) ? yr - 1 : yr;
        era  = y / 400;
        yoe  = y - era * 400;
        mp   = (mo > 2) ? mo - 3 : mo + 9;
        doy  = (153 * mp + 2) / 5 + dd - 1;
        doe  = yoe * 365 + yoe / 4 - yoe / 100 + doy;
        days = era * 146097 + doe - 719468;
        total = 64'(days) * 64'd86400 + 64'(hr * 3600 + mn * 60 + sec);
        r.epoch_secs = total[31:0];
        r.status = 1'b0;
        return r;
    endfunction

    function automatic item_t make_item(input logic [7:0] hr, input logic [7:0] mn,
                                        input logic [7:0] sc, input logic [7:0] yr,
                                        input logic [7:0] mo, input logic [7:0] dy,
                                        input logic [31:0] tnoise, input logic [31:0] dnoise);
        item_t it;
        it.time_word = {tnoise[31:22], hr[5:0], tnoise[15], mn[6:0], tnoise[7], sc[6:0]};
        it.date_word = {dnoise[31:24], yr, dnoise[15:13], mo[4:0], dnoise[7:6], dy[5:0]};
        return it;
    endfunction

    // Raw field of the given width whose decoded value is inside or outside lo..hi.
    function automatic logic [7:0] pick_field(input int bits, input int lo, input int hi,
                                              input bit in_range);
        logic [7:0]  raw;
        int unsigned v;
        if (in_range && $urandom_range(1) == 1)
        begin
            v = $urandom_range(hi, lo);
            return {4'(v / 10), 4'(v % 10)};
        end
        do
        begin
            raw = 8'($urandom) & 8'((1 << bits) - 1);
            v = digit_pair(raw);
        end
        while (((v >= lo) && (v <= hi)) != in_range);
        return raw;
    endfunction

    function automatic item_t random_item();
        int unsigned kind, broken;
        kind = $urandom_range(99);
        if (kind >= 80)
            return item_t'({$urandom(), $urandom()});
        broken = (kind >= 65) ? $urandom_range(4) : 5;
        return make_item(pick_field(6, 0, 23, broken != 0), pick_field(7, 0, 59, broken != 1),
                         pick_field(7, 0, 59, broken != 2), 8'($urandom),
                         pick_field(5, 1, 12, broken != 3), pick_field(6, 1, 31, broken != 4),
                         $urandom, $urandom);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < REPORT_CAP)
            $display("%0t: %s: got %h, want %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic send_item(input item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        pending_stamps.push_back(civil_to_unix(it));
    endtask

    task automatic wait_for_drain();
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_stamps.size() != 0);
    endtask

    task automatic test_field_limits();
        send_item(make_item(8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01, '0, '0));
        send_item(make_item(8'h23, 8'h59, 8'h59, 8'h99, 8'h12, 8'h31, '1, '1));
        send_item(make_item(8'h23, 8'h59, 8'h59, 8'hFF, 8'h12, 8'h31, '0, '1));
        send_item('0);
        send_item('1);
    endtask

    task automatic test_nonbcd_digits();
        send_item(make_item(8'h0F, 8'h4F, 8'h3F, 8'h9F, 8'h0A, 8'h0F, '0, '0));
        send_item(make_item(8'h1A, 8'h0E, 8'h2D, 8'hA0, 8'h0B, 8'h1F, '1, '0));
        send_item(make_item(8'h09, 8'h5F, 8'h0C, 8'hEE, 8'h0C, 8'h2B, '0, '1));
    endtask

    task automatic test_range_errors();
        send_item(make_item(8'h12, 8'h30, 8'h30, 8'h24, 8'h13, 8'h15, '0, '0));
        send_item(make_item(8'h12, 8'h30, 8'h30, 8'h24, 8'h00, 8'h15, '0, '0));
        send_item(make_item(8'h12, 8'h30, 8'h30, 8'h24, 8'h0D, 8'h15, '0, '0));
        send_item(make_item(8'h12, 8'h30, 8'h30, 8'h24, 8'h06, 8'h00, '0, '0));
        send_item(make_item(8'h12, 8'h30, 8'h30, 8'h24, 8'h06, 8'h32, '0, '0));
        send_item(make_item(8'h12, 8'h30, 8'h30, 8'h24, 8'h06, 8'h3F, '0, '0));
        send_item(make_item(8'h24, 8'h30, 8'h30, 8'h24, 8'h06, 8'h15, '0, '0));
        send_item(make_item(8'h3F, 8'h30, 8'h30, 8'h24, 8'h06, 8'h15, '0, '0));
        send_item(make_item(8'h12, 8'h60, 8'h30, 8'h24, 8'h06, 8'h15, '0, '0));
        send_item(make_item(8'h12, 8'h7F, 8'h30, 8'h24, 8'h06, 8'h15, '0, '0));
        send_item(make_item(8'h12, 8'h30, 8'h60, 8'h24, 8'h06, 8'h15, '0, '0));
    endtask

    task automatic test_impossible_days();
        send_item(make_item(8'h08, 8'h15, 8'h00, 8'h01, 8'h02, 8'h31, '0, '0));
        send_item(make_item(8'h08, 8'h15, 8'h00, 8'hA0, 8'h02, 8'h29, '0, '0));
        send_item(make_item(8'h08, 8'h15, 8'h00, 8'h24, 8'h04, 8'h31, '0, '0));
        send_item(make_item(8'h23, 8'h59, 8'h59, 8'h00, 8'h02, 8'h29, '0, '0));
        send_item(make_item(8'h00, 8'h00, 8'h00, 8'h00, 8'h03, 8'h01, '0, '0));
    endtask

    task automatic test_random_traffic(input int unsigned count, input int unsigned idle,
                                       input int unsigned stall);
        send_idle_pct = idle;
        stall_pct = stall;
        for (int unsigned i = 0; i < count; i++)
        begin
            send_item(random_item());
            // hold off the sender once until every pending stamp is back
            if (i == count / 2)
                wait_for_drain();
        end
        wait_for_drain();
    endtask

    always @(posedge clk)
        result_stall <= ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_stamps.size() == 0)
                report_mismatch("unexpected result", result.epoch_secs, '0);
            else
            begin
                want = pending_stamps.pop_front();
                if (result.epoch_secs !== want.epoch_secs)
                    report_mismatch("epoch_secs", result.epoch_secs, want.epoch_secs);
                if (result.status !== want.status)
                    report_mismatch("status", 32'(result.status), 32'(want.status));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= WATCHDOG_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_field_limits();
        test_nonbcd_digits();
        test_range_errors();
        test_impossible_days();
        wait_for_drain();
        test_random_traffic(340, 0, 0);
        test_random_traffic(330, 76, 0);
        test_random_traffic(330, 0, 76);
        test_random_traffic(330, 12, 12);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_stamps.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: bcd_calendar_to_unix_seconds_core.f
src/bcdu_pkg.sv
src/bcdu_front.sv
src/bcdu_queue.sv
src/bcdu_back.sv
src/bcd_calendar_to_unix_seconds_core.sv
test/bcd_calendar_to_unix_seconds_core_tb.sv
